@@ sv/hslp_pkg.sv @@
// shared constants, types and codes for the hsl palette color generator
package hslp_pkg;

	localparam int HUE_W  = 13;
	localparam int Q_W    = 9;
	localparam int LQ_W   = 11;
	localparam int HM_W   = 11;
	localparam int F_W    = 10;
	localparam int CN_W   = 19;
	localparam int COMP_W = 30;
	localparam int V_W    = 31;
	localparam int P_W    = V_W + 8;
	localparam int W_W    = 18;
	localparam int RP_W   = 34;
	localparam int QE_W   = 10;
	localparam int C_W    = 8;

	localparam logic [HUE_W-1:0] HUE_FULL     = 13'd5760;
	localparam logic [HUE_W-1:0] HUE_SECTOR   = 13'd960;
	localparam logic [13:0]      HUE_FULL2    = 14'd11520;
	localparam logic [Q_W-1:0]   Q_ONE        = 9'd256;
	localparam logic [LQ_W-1:0]  LQ_ONE       = 11'd1280;
	localparam logic [LQ_W-1:0]  LQ_HALF      = 11'd640;
	localparam logic [LQ_W-1:0]  LQ_RAINBOW   = 11'd768;
	localparam logic [15:0]      RECIP_300    = 16'd55924;
	localparam logic [W_W-1:0]   DIV_300      = 18'd300;
	localparam logic [W_W-1:0]   W_MAX        = 18'd76500;
	localparam logic [C_W-1:0]   C_MAX        = 8'd255;

	typedef enum logic {
		CMD_HSL     = 1'b0,
		CMD_PALETTE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		PAL_RAINBOW = 3'd0,
		PAL_FIRE    = 3'd1,
		PAL_ICE     = 3'd2,
		PAL_NEON    = 3'd3
	} pal_t;

	typedef logic [COMP_W-1:0] comp_t;
	typedef logic [C_W-1:0]    color_t;

	// per-stage advance for the back half of the pipe
	typedef struct packed {
		logic en_s5;
		logic en_s6;
		logic en_s7;
		logic en_s8;
		logic vld_s7;
	} chan_ctl_t;

endpackage

@@ sv/hsl_palette_color_generator_core.sv @@
// top level of the hsl palette color generator
// Takes one item per clock while stall is low and returns one RGB color per
// item, in order. The pipeline has eight register stages: input
// decode, hue sector and chroma terms, chroma multiply, component multiply,
// offset add, scale by 255, reciprocal divide, and a correction stage that
// drives the output registers. A stall on the result side holds only the
// filled stages; empty stages keep taking new beats, so the input side stalls
// only when all eight stages hold an item.
module hsl_palette_color_generator_core import hslp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  logic             cmd,
	input  logic [HUE_W-1:0] hue,
	input  logic [Q_W-1:0]   saturation,
	input  logic [Q_W-1:0]   lightness,
	input  logic [2:0]       palette,
	input  logic [Q_W-1:0]   level,
	output logic             rgb_valid,
	input  logic             rgb_stall,
	output logic [C_W-1:0]   red,
	output logic [C_W-1:0]   green,
	output logic [C_W-1:0]   blue
);

	function automatic color_t scale_t(input logic [Q_W-1:0] t, input logic [7:0] k);
		logic [16:0] p;
		p = 17'(t) * 17'(k);
		return p[15:8];
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	// stage 1
	logic [HUE_W-1:0] hq_s1;
	logic [Q_W-1:0]   sq_s1;
	logic [LQ_W-1:0]  lq_s1;
	logic             hsl_s1, fire_s1;
	logic [16:0]      tt_s1;
	color_t           pr_s1, pg_s1, pb_s1;
	// stage 2
	logic [F_W-1:0]   f_s2;
	logic [2:0]       sector_s2;
	logic [LQ_W-1:0]  g_s2, lq_s2;
	logic [Q_W-1:0]   sq_s2;
	logic             hsl_s2;
	color_t           pr_s2, pg_s2, pb_s2;
	// stage 3
	logic [CN_W-1:0]  cn_s3;
	logic [F_W-1:0]   f_s3;
	logic [2:0]       sector_s3;
	logic [LQ_W-1:0]  lq_s3;
	logic             hsl_s3;
	color_t           pr_s3, pg_s3, pb_s3;
	// stage 4
	comp_t            cpart_s4, xpart_s4, mpart_s4;
	logic [2:0]       sector_s4;
	logic             hsl_s4;
	color_t           pr_s4, pg_s4, pb_s4;

	logic [Q_W-1:0]   s_c, l_c, t_c;
	logic [HUE_W-1:0] hue_w, hue_rb;
	logic [13:0]      th;
	logic             hsl_in;
	color_t           pr_in, pg_in, pb_in;
	logic [HM_W-1:0]  hm;
	logic [2:0]       sector_in;
	logic [LQ_W:0]    lq2;
	logic [23:0]      fire_b;
	logic [CN_W+F_W-1:0] cnf;
	comp_t            r_comp, g_comp, b_comp;
	chan_ctl_t        ctl;

	// handshake: a stage advances when empty or when the next one advances
	assign en_s8 = !valid_s8 || !rgb_stall;
	assign en_s7 = !valid_s7 || en_s8;
	assign en_s6 = !valid_s6 || en_s7;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign stall = !en_s1;
	assign rgb_valid = valid_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
		end
	end

	// stage 1 input decode
	always_comb begin
		s_c    = (saturation > Q_ONE) ? Q_ONE : saturation;
		l_c    = (lightness > Q_ONE) ? Q_ONE : lightness;
		t_c    = (level > Q_ONE) ? Q_ONE : level;
		hue_w  = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
		// rainbow hue (t*720 deg) in sixteenths is t*45, reduced mod 5760
		th     = 14'(t_c) * 14'd45;
		if (th >= HUE_FULL2)
			hue_rb = HUE_W'(th - HUE_FULL2);
		else if (th >= 14'(HUE_FULL))
			hue_rb = HUE_W'(th - 14'(HUE_FULL));
		else
			hue_rb = th[HUE_W-1:0];
		hsl_in = (cmd == CMD_HSL) || (palette == PAL_RAINBOW);
		case (palette)
			PAL_FIRE: begin
				pr_in = C_MAX;
				pg_in = 8'd80 + scale_t(t_c, 8'd175);
				pb_in = '0;
			end
			PAL_ICE: begin
				pr_in = 8'd100 + scale_t(t_c, 8'd155);
				pg_in = 8'd150 + scale_t(t_c, 8'd105);
				pb_in = C_MAX;
			end
			PAL_NEON: begin
				pr_in = 8'd200 + scale_t(t_c, 8'd55);
				pg_in = 8'd50 + scale_t(t_c, 8'd100);
				pb_in = C_MAX;
			end
			default: begin
				pr_in = C_MAX;
				pg_in = C_MAX;
				pb_in = C_MAX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			if (cmd == CMD_HSL) begin
				hq_s1 <= hue_w;
				sq_s1 <= s_c;
				lq_s1 <= LQ_W'(l_c) * LQ_W'(5);
			end else begin
				hq_s1 <= hue_rb;
				sq_s1 <= Q_ONE;
				lq_s1 <= LQ_RAINBOW;
			end
			hsl_s1  <= hsl_in;
			fire_s1 <= (palette == PAL_FIRE);
			tt_s1   <= 17'(t_c) * 17'(t_c);
			pr_s1   <= pr_in;
			pg_s1   <= pg_in;
			pb_s1   <= pb_in;
		end
	end

	// stage 2 hue sector, fractional position and lightness term
	always_comb begin
		if (hq_s1 >= 13'd3840)
			hm = HM_W'(hq_s1 - 13'd3840);
		else if (hq_s1 >= 13'd1920)
			hm = HM_W'(hq_s1 - 13'd1920);
		else
			hm = hq_s1[HM_W-1:0];
		if (hq_s1 < 13'd960)       sector_in = 3'd0;
		else if (hq_s1 < 13'd1920) sector_in = 3'd1;
		else if (hq_s1 < 13'd2880) sector_in = 3'd2;
		else if (hq_s1 < 13'd3840) sector_in = 3'd3;
		else if (hq_s1 < 13'd4800) sector_in = 3'd4;
		else                       sector_in = 3'd5;
		lq2    = {lq_s1, 1'b0};
		fire_b = 24'(tt_s1) * 24'd80;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			f_s2      <= (hm >= HM_W'(HUE_SECTOR)) ? F_W'(11'd1920 - hm) : hm[F_W-1:0];
			sector_s2 <= sector_in;
			g_s2      <= (lq_s1 >= LQ_HALF) ? LQ_W'(12'd2560 - lq2) : lq2[LQ_W-1:0];
			lq_s2     <= lq_s1;
			sq_s2     <= sq_s1;
			hsl_s2    <= hsl_s1;
			pr_s2     <= pr_s1;
			pg_s2     <= pg_s1;
			pb_s2     <= fire_s1 ? fire_b[23:16] : pb_s1;
		end
	end

	// stage 3 chroma
	always_ff @(posedge clk) begin
		if (en_s3) begin
			cn_s3     <= CN_W'(g_s2) * CN_W'(sq_s2);
			f_s3      <= f_s2;
			sector_s3 <= sector_s2;
			lq_s3     <= lq_s2;
			hsl_s3    <= hsl_s2;
			pr_s3     <= pr_s2;
			pg_s3     <= pg_s2;
			pb_s3     <= pb_s2;
		end
	end

	// stage 4 terms over the common denominator 960 * 655360
	assign cnf = (CN_W + F_W)'(cn_s3) * (CN_W + F_W)'(f_s3);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cpart_s4  <= COMP_W'(cn_s3) * COMP_W'(1920);
			xpart_s4  <= {cnf[COMP_W-2:0], 1'b0};
			mpart_s4  <= COMP_W'(lq_s3) * COMP_W'(491520) - COMP_W'(cn_s3) * COMP_W'(960);
			sector_s4 <= sector_s3;
			hsl_s4    <= hsl_s3;
			pr_s4     <= pr_s3;
			pg_s4     <= pg_s3;
			pb_s4     <= pb_s3;
		end
	end

	always_comb begin
		case (sector_s4)
			3'd0: begin r_comp = cpart_s4; g_comp = xpart_s4; b_comp = '0;       end
			3'd1: begin r_comp = xpart_s4; g_comp = cpart_s4; b_comp = '0;       end
			3'd2: begin r_comp = '0;       g_comp = cpart_s4; b_comp = xpart_s4; end
			3'd3: begin r_comp = '0;       g_comp = xpart_s4; b_comp = cpart_s4; end
			3'd4: begin r_comp = xpart_s4; g_comp = '0;       b_comp = cpart_s4; end
			default: begin r_comp = cpart_s4; g_comp = '0;    b_comp = xpart_s4; end
		endcase
	end

	assign ctl.en_s5  = en_s5;
	assign ctl.en_s6  = en_s6;
	assign ctl.en_s7  = en_s7;
	assign ctl.en_s8  = en_s8;
	assign ctl.vld_s7 = valid_s7;

	hslp_chan u_red (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.comp    (r_comp),
		.mpart   (mpart_s4),
		.pal_val (pr_s4),
		.use_hsl (hsl_s4),
		.color   (red)
	);

	hslp_chan u_green (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.comp    (g_comp),
		.mpart   (mpart_s4),
		.pal_val (pg_s4),
		.use_hsl (hsl_s4),
		.color   (green)
	);

	hslp_chan u_blue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.comp    (b_comp),
		.mpart   (mpart_s4),
		.pal_val (pb_s4),
		.use_hsl (hsl_s4),
		.color   (blue)
	);

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall |=> valid_s1)
		else $error("accepted beat did not enter the pipe");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en_s1 |=> valid_s1 && $stable(hq_s1) && $stable(lq_s1) && $stable(sq_s1))
		else $error("held stage changed under stall");

	a_s2_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (f_s2 <= F_W'(HUE_SECTOR)) && (sector_s2 <= 3'd5) && (g_s2 <= LQ_ONE))
		else $error("hue sector terms out of range");

	a_offset_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> 20'(cn_s3) <= 20'(lq_s3) * 20'd512)
		else $error("negative lightness offset");

endmodule

@@ sv/hslp_chan.sv @@
// one color channel: offset add, scale by 255 and divide down to 8 bits, or pass the palette value
module hslp_chan import hslp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  chan_ctl_t ctl,
	input  comp_t     comp,
	input  comp_t     mpart,
	input  color_t    pal_val,
	input  logic      use_hsl,
	output color_t    color
);

	logic [V_W-1:0]  v_s5;
	logic [W_W-1:0]  w_s6, w_s7;
	logic [QE_W-1:0] qe_s7;
	color_t          pal_s5, pal_s6, pal_s7, color_s8;
	logic            hsl_s5, hsl_s6, hsl_s7;

	logic [P_W-1:0]  p_v255;
	logic [RP_W-1:0] p_recip;
	logic [W_W-1:0]  qe_x300;
	logic [W_W-1:0]  rem;
	logic [QE_W-1:0] q_fix;
	color_t          q_sat;

	// v*255 = (v << 8) - v, then drop the 2^21 part of the 629145600 denominator
	assign p_v255  = {v_s5, 8'd0} - P_W'(v_s5);
	// floor(w / 300) via reciprocal, off by at most one low
	assign p_recip = RP_W'(w_s6) * RP_W'(RECIP_300);
	assign qe_x300 = W_W'(qe_s7) * DIV_300;
	assign rem     = w_s7 - qe_x300;
	assign q_fix   = (rem >= DIV_300) ? qe_s7 + QE_W'(1) : qe_s7;
	assign q_sat   = (q_fix > QE_W'(C_MAX)) ? C_MAX : q_fix[C_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			v_s5   <= V_W'(comp) + V_W'(mpart);
			pal_s5 <= pal_val;
			hsl_s5 <= use_hsl;
		end
		if (ctl.en_s6) begin
			w_s6   <= p_v255[P_W-1:21];
			pal_s6 <= pal_s5;
			hsl_s6 <= hsl_s5;
		end
		if (ctl.en_s7) begin
			qe_s7  <= p_recip[RP_W-1:24];
			w_s7   <= w_s6;
			pal_s7 <= pal_s6;
			hsl_s7 <= hsl_s6;
		end
		if (ctl.en_s8) begin
			color_s8 <= hsl_s7 ? q_sat : pal_s7;
		end
	end

	assign color = color_s8;

	a_recip_low: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld_s7 |-> (qe_x300 <= w_s7) && (rem < (DIV_300 + DIV_300)))
		else $error("reciprocal quotient off by more than one");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld_s7 && hsl_s7 |-> w_s7 <= W_MAX)
		else $error("scaled component above full scale");

endmodule

@@ verif/tb_hsl_palette_color_generator_core.sv @@
// self-checking testbench for the hsl palette color generator core
`timescale 1ns / 1ps

module tb_hsl_palette_color_generator_core import hslp_pkg::*; ();

	localparam longint unsigned COLOR_DENOM = 64'd629145600;  // 960 * 1280 * 512
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BEATS   = 1575;

	typedef struct {
		cmd_t             cmd;
		logic [HUE_W-1:0] hue;
		logic [Q_W-1:0]   sat;
		logic [Q_W-1:0]   light;
		logic [2:0]       pal;
		logic [Q_W-1:0]   lvl;
		bit               drain;   // hold this beat back until the pipe is empty
	} color_req_t;

	typedef struct packed {
		color_t r;
		color_t g;
		color_t b;
	} rgb_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             valid      = 1'b0;
	logic             stall;
	logic             cmd        = CMD_HSL;
	logic [HUE_W-1:0] hue        = '0;
	logic [Q_W-1:0]   saturation = '0;
	logic [Q_W-1:0]   lightness  = '0;
	logic [2:0]       palette    = '0;
	logic [Q_W-1:0]   level      = '0;
	logic             rgb_valid;
	logic             rgb_stall  = 1'b0;
	logic [C_W-1:0]   red;
	logic [C_W-1:0]   green;
	logic [C_W-1:0]   blue;

	color_req_t pending_reqs[$];
	rgb_t       expected_colors[$];
	color_req_t cur_req;
	rgb_t       want_color;
	int         mismatch_count = 0;
	int         gap_left       = 0;
	int         quiet_in       = 0;
	int         stall_left     = 0;
	int         quiet_out      = 0;
	int         idle_cycles    = 0;

	hsl_palette_color_generator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.stall      (stall),
		.cmd        (cmd),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.palette    (palette),
		.level      (level),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned clamp_unit(longint unsigned v);
		return (v > Q_ONE) ? longint'(Q_ONE) : v;
	endfunction

	function automatic color_t sat_byte(longint unsigned v);
		return (v > C_MAX) ? C_MAX : color_t'(v);
	endfunction

	function automatic longint unsigned abs_diff(longint unsigned a, longint unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	// hq in 1/16 degree, sq in Q1.8, lq in 1/1280 units; all terms over one denominator
	function automatic rgb_t hsl_to_rgb(longint unsigned hq, longint unsigned sq,
			longint unsigned lq);
		longint unsigned chroma, hm, ramp, cterm, xterm, mterm;
		longint unsigned comp[3];
		rgb_t o;
		if (hq >= HUE_FULL)
			hq = hq - HUE_FULL;
		chroma = (LQ_ONE - abs_diff(2 * lq, LQ_ONE)) * sq;
		hm     = hq % (2 * HUE_SECTOR);
		ramp   = HUE_SECTOR - abs_diff(hm, HUE_SECTOR);
		cterm  = chroma * 2 * HUE_SECTOR;
		xterm  = chroma * ramp * 2;
		mterm  = lq * 512 * HUE_SECTOR - chroma * HUE_SECTOR;
		case (hq / HUE_SECTOR)
			0: begin comp[0] = cterm; comp[1] = xterm; comp[2] = 0;     end
			1: begin comp[0] = xterm; comp[1] = cterm; comp[2] = 0;     end
			2: begin comp[0] = 0;     comp[1] = cterm; comp[2] = xterm; end
			3: begin comp[0] = 0;     comp[1] = xterm; comp[2] = cterm; end
			4: begin comp[0] = xterm; comp[1] = 0;     comp[2] = cterm; end
			default: begin comp[0] = cterm; comp[1] = 0; comp[2] = xterm; end
		endcase
		o.r = sat_byte(((comp[0] + mterm) * 255) / COLOR_DENOM);
		o.g = sat_byte(((comp[1] + mterm) * 255) / COLOR_DENOM);
		o.b = sat_byte(((comp[2] + mterm) * 255) / COLOR_DENOM);
		return o;
	endfunction

	function automatic rgb_t predict_color(color_req_t req);
		longint unsigned sq, lq, t, r, g, b;
		sq = clamp_unit(req.sat);
		lq = clamp_unit(req.light);
		t  = clamp_unit(req.lvl);
		if (req.cmd == CMD_HSL)
			return hsl_to_rgb(req.hue, sq, lq * 5);
		case (req.pal)
			PAL_RAINBOW: return hsl_to_rgb((t * 45) % HUE_FULL, Q_ONE, LQ_RAINBOW);
			PAL_FIRE: begin
				r = 255;
				g = 80 + (t * 175) / 256;
				b = (t * t * 80) / 65536;
			end
			PAL_ICE: begin
				r = 100 + (t * 155) / 256;
				g = 150 + (t * 105) / 256;
				b = 255;
			end
			PAL_NEON: begin
				r = 200 + (t * 55) / 256;
				g = 50 + (t * 100) / 256;
				b = 255;
			end
			default: begin
				r = 255;
				g = 255;
				b = 255;
			end
		endcase
		return '{r: sat_byte(r), g: sat_byte(g), b: sat_byte(b)};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// q1.8 value weighted toward the ends and the clamped range
	function automatic int rand_q();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 16)
			return 256;
		if (r < 26)
			return $urandom_range(257, 511);
		return $urandom_range(0, 256);
	endfunction

	task automatic add_req(cmd_t c, int h, int s, int l, int p, int t, bit drain);
		color_req_t req;
		req.cmd   = c;
		req.hue   = h[HUE_W-1:0];
		req.sat   = s[Q_W-1:0];
		req.light = l[Q_W-1:0];
		req.pal   = p[2:0];
		req.lvl   = t[Q_W-1:0];
		req.drain = drain;
		pending_reqs = {pending_reqs, req};
	endtask

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// input side: one beat presented at a time, held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			if (valid && !stall)
				expected_colors = {expected_colors, predict_color(cur_req)};
			if (!valid || !stall) begin
				if (gap_left > 0) begin
					valid <= 1'b0;
					gap_left--;
				end else if (pending_reqs.size() == 0 ||
						(pending_reqs[0].drain && expected_colors.size() != 0)) begin
					valid <= 1'b0;
				end else begin
					cur_req = pending_reqs[0];
					pending_reqs.delete(0);
					cmd        <= cur_req.cmd;
					hue        <= cur_req.hue;
					saturation <= cur_req.sat;
					lightness  <= cur_req.light;
					palette    <= cur_req.pal;
					level      <= cur_req.lvl;
					valid      <= 1'b1;
					if (quiet_in > 0) begin
						quiet_in--;
						gap_left = 0;
					end else begin
						gap_left = pick_gap();
						if ($urandom_range(0, 99) < 3)
							quiet_in = $urandom_range(20, 120);
					end
				end
			end
		end
	end

	// result side: compare each beat against the oldest prediction, random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_stall <= 1'b0;
		end else begin
			if (rgb_valid && !rgb_stall) begin
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("unexpected beat %0d/%0d/%0d", red, green, blue));
				end else begin
					want_color = expected_colors[0];
					expected_colors.delete(0);
					if (red !== want_color.r)
						report_mismatch($sformatf("red got %0d want %0d", red, want_color.r));
					if (green !== want_color.g)
						report_mismatch($sformatf("green got %0d want %0d", green, want_color.g));
					if (blue !== want_color.b)
						report_mismatch($sformatf("blue got %0d want %0d", blue, want_color.b));
				end
			end
			if (stall_left > 0) begin
				rgb_stall <= 1'b1;
				stall_left--;
			end else begin
				rgb_stall <= 1'b0;
				if (quiet_out > 0)
					quiet_out--;
				else if ($urandom_range(0, 99) < 2)
					quiet_out = $urandom_range(20, 120);
				else if ($urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((valid && !stall) || (rgb_valid && !rgb_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("hsl_palette_color_generator_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		// sector edges, hue wrap, clamped and degenerate hsl inputs
		add_req(CMD_HSL, 0, 256, 128, 0, 0, 1'b0);
		add_req(CMD_HSL, 960, 256, 128, 7, 511, 1'b0);
		add_req(CMD_HSL, 1920, 256, 128, 0, 0, 1'b0);
		add_req(CMD_HSL, 2880, 256, 128, 5, 256, 1'b0);
		add_req(CMD_HSL, 3840, 256, 128, 0, 0, 1'b0);
		add_req(CMD_HSL, 4800, 256, 128, 3, 100, 1'b0);
		add_req(CMD_HSL, 5759, 256, 128, 0, 0, 1'b0);
		add_req(CMD_HSL, 5760, 256, 128, 0, 0, 1'b0);
		add_req(CMD_HSL, 8191, 511, 511, 7, 511, 1'b0);
		add_req(CMD_HSL, 959, 256, 64, 0, 0, 1'b0);
		add_req(CMD_HSL, 480, 0, 128, 0, 0, 1'b0);
		add_req(CMD_HSL, 2000, 256, 0, 0, 0, 1'b0);
		add_req(CMD_HSL, 3000, 256, 256, 0, 0, 1'b0);
		add_req(CMD_HSL, 4000, 300, 200, 0, 0, 1'b0);
		add_req(CMD_HSL, 1234, 128, 300, 0, 0, 1'b0);
		// every palette code at full level, hsl fields set to junk
		for (int p = 0; p < 8; p++)
			add_req(CMD_PALETTE, 8191, 511, 511, p, 256, 1'b0);
		add_req(CMD_PALETTE, 0, 0, 0, PAL_RAINBOW, 0, 1'b0);
		add_req(CMD_PALETTE, 0, 0, 0, PAL_RAINBOW, 128, 1'b0);
		add_req(CMD_PALETTE, 0, 0, 0, PAL_FIRE, 511, 1'b0);
		add_req(CMD_PALETTE, 0, 0, 0, PAL_ICE, 0, 1'b0);
		add_req(CMD_PALETTE, 0, 0, 0, PAL_NEON, 128, 1'b0);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			add_req(($urandom_range(0, 1) != 0) ? CMD_PALETTE : CMD_HSL,
				($urandom_range(0, 9) == 0) ? $urandom_range(5760, 8191) : $urandom_range(0, 5759),
				rand_q(), rand_q(), $urandom_range(0, 7), rand_q(),
				(i == 0) || (i % 400 == 399));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || valid || expected_colors.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("hsl_palette_color_generator_core regression: pass");
		else
			$display("hsl_palette_color_generator_core regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/hslp_pkg.sv
sv/hslp_chan.sv
sv/hsl_palette_color_generator_core.sv
verif/tb_hsl_palette_color_generator_core.sv
